/* design/macd_pkg.sv */
// ----------------------------------------------------------------------------
// macd_pkg: shared types and constants of the MACD indicator
// Fixed-point widths, register indexes and datapath operation codes used by
// the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package macd_pkg;

    // Fixed-point formats
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int EXTRA_FRAC_BITS  = 16;

    localparam int PRICE_W = 32;                      // unsigned Q16.16 price
    localparam int AVG_W   = PRICE_W + EXTRA_FRAC_BITS; // price averages
    localparam int DIF_W   = AVG_W + 1;               // signed DIF and DEA
    localparam int HIST_W  = DIF_W + 1;               // signed histogram
    localparam int DIFF_W  = HIST_W;                  // EMA difference operand
    localparam int CFG_W   = 17;                      // weight register width
    localparam int WT_W    = WEIGHT_FRAC_BITS + 1;    // clamped weight, up to 1.0
    localparam int PROD_W  = DIFF_W + WT_W + 1;       // signed product
    localparam int OUT_W   = ((2 * DIF_W + HIST_W + 7) / 8) * 8;

    localparam logic [31:0] ONE_WEIGHT = 32'(1) << WEIGHT_FRAC_BITS;

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_WEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_WEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_WEIGHT = 2'd2;

    localparam logic [CFG_W-1:0] FAST_WEIGHT_RST   = 17'd10082;
    localparam logic [CFG_W-1:0] SLOW_WEIGHT_RST   = 17'd4855;
    localparam logic [CFG_W-1:0] SIGNAL_WEIGHT_RST = 17'd13107;

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_RESTART  = 4'd1;  // load averages with the price
    localparam logic [OP_W-1:0] OP_LOAD     = 4'd2;  // latch price, form price - fast
    localparam logic [OP_W-1:0] OP_MUL_FAST = 4'd3;  // multiply by fast weight, form price - slow
    localparam logic [OP_W-1:0] OP_MUL_SLOW = 4'd4;  // update fast, multiply by slow weight
    localparam logic [OP_W-1:0] OP_UPD_SLOW = 4'd5;  // update slow
    localparam logic [OP_W-1:0] OP_DIF      = 4'd6;  // DIF = fast - slow
    localparam logic [OP_W-1:0] OP_SEED     = 4'd7;  // DEA = DIF
    localparam logic [OP_W-1:0] OP_SIG_DIFF = 4'd8;  // form DIF - DEA
    localparam logic [OP_W-1:0] OP_MUL_SIG  = 4'd9;  // multiply by signal weight
    localparam logic [OP_W-1:0] OP_UPD_SIG  = 4'd10; // update DEA

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            out_load;
    } t_dp_cmd;

    // Clamp a weight register to at most 1.0
    function automatic logic [WT_W-1:0] clamp_weight(input logic [CFG_W-1:0] w);
        logic [31:0] wx;
        wx = 32'(w);
        if (wx > ONE_WEIGHT) begin
            return WT_W'(ONE_WEIGHT);
        end
        return WT_W'(wx);
    endfunction

endpackage

/* design/macd_dp.sv */
// ----------------------------------------------------------------------------
// macd_dp: MACD datapath
// Weight registers, the three averages and one shared multiplier that the
// controller steps through the fast, slow and signal updates.
// ----------------------------------------------------------------------------
module macd_dp import macd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [PRICE_W-1:0]   i_price,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic [OUT_W-1:0]     o_result
);

    logic [CFG_W-1:0]         r_fast_w, r_slow_w, r_sig_w;
    logic [AVG_W-1:0]         r_px, r_fast, r_slow;
    logic signed [DIF_W-1:0]  r_dif, r_dea;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic [OUT_W-1:0]         r_result;

    logic [AVG_W-1:0]         w_px_in;
    logic [WT_W-1:0]          w_weight;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [DIFF_W-1:0] w_step;
    logic signed [HIST_W-1:0] w_hist;

    assign w_px_in = AVG_W'(i_price) << EXTRA_FRAC_BITS;

    always_comb begin
        unique case (i_cmd.op)
            OP_MUL_FAST: w_weight = clamp_weight(r_fast_w);
            OP_MUL_SLOW: w_weight = clamp_weight(r_slow_w);
            default:     w_weight = clamp_weight(r_sig_w);
        endcase
    end

    // One shared multiplier; the product is always registered before use.
    assign w_prod = PROD_W'(r_diff) * $signed({1'b0, w_weight});
    // Arithmetic shift floors toward minus infinity, as the EMA step requires.
    assign w_step = DIFF_W'(r_prod >>> WEIGHT_FRAC_BITS);
    assign w_hist = HIST_W'(r_dif) - HIST_W'(r_dea);

    // Weight registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_w <= FAST_WEIGHT_RST;
            r_slow_w <= SLOW_WEIGHT_RST;
            r_sig_w  <= SIGNAL_WEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FAST_WEIGHT:   r_fast_w <= i_cfg_data;
                REG_SLOW_WEIGHT:   r_slow_w <= i_cfg_data;
                REG_SIGNAL_WEIGHT: r_sig_w  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Averages and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast <= '0;
            r_slow <= '0;
            r_dea  <= '0;
            r_dif  <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_RESTART: begin
                    r_fast <= w_px_in;
                    r_slow <= w_px_in;
                    r_dea  <= '0;
                    r_dif  <= '0;
                end
                OP_MUL_SLOW: r_fast <= AVG_W'(DIFF_W'(r_fast) + w_step);
                OP_UPD_SLOW: r_slow <= AVG_W'(DIFF_W'(r_slow) + w_step);
                OP_DIF:      r_dif  <= DIF_W'({1'b0, r_fast}) - DIF_W'({1'b0, r_slow});
                OP_SEED:     r_dea  <= r_dif;
                OP_UPD_SIG:  r_dea  <= DIF_W'(DIFF_W'(r_dea) + w_step);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_px   <= w_px_in;
                r_diff <= DIFF_W'({1'b0, w_px_in}) - DIFF_W'({1'b0, r_fast});
            end
            OP_MUL_FAST: begin
                r_prod <= w_prod;
                r_diff <= DIFF_W'({1'b0, r_px}) - DIFF_W'({1'b0, r_slow});
            end
            OP_MUL_SLOW: r_prod <= w_prod;
            OP_SIG_DIFF: r_diff <= DIFF_W'(r_dif) - DIFF_W'(r_dea);
            OP_MUL_SIG:  r_prod <= w_prod;
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_result <= OUT_W'({w_hist, r_dea, r_dif});
        end
    end

    assign o_result = r_result;

endmodule

/* design/macd_ctrl.sv */
// ----------------------------------------------------------------------------
// macd_ctrl: MACD controller
// Sequences the datapath through one bar, tracks the bar position in the
// series and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module macd_ctrl import macd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_series_start,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MULF = 4'd1;
    localparam logic [3:0] ST_MULS = 4'd2;
    localparam logic [3:0] ST_UPDS = 4'd3;
    localparam logic [3:0] ST_DIF  = 4'd4;
    localparam logic [3:0] ST_SEED = 4'd5;
    localparam logic [3:0] ST_SIGD = 4'd6;
    localparam logic [3:0] ST_MULG = 4'd7;
    localparam logic [3:0] ST_UPDG = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    localparam logic [1:0] POS_NONE = 2'd0;
    localparam logic [1:0] POS_ONE  = 2'd1;
    localparam logic [1:0] POS_MANY = 2'd2;

    logic [3:0] r_state, n_state;
    logic [1:0] r_pos, n_pos;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        n_pos          = r_pos;
        n_out_valid    = r_out_valid && !i_out_ready;
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_series_start || r_pos == POS_NONE) begin
                        o_cmd.op = OP_RESTART;
                        n_pos    = POS_ONE;
                        n_state  = ST_DONE;
                    end else begin
                        o_cmd.op = OP_LOAD;
                        n_state  = ST_MULF;
                    end
                end
            end
            ST_MULF: begin
                o_cmd.op = OP_MUL_FAST;
                n_state  = ST_MULS;
            end
            ST_MULS: begin
                o_cmd.op = OP_MUL_SLOW;
                n_state  = ST_UPDS;
            end
            ST_UPDS: begin
                o_cmd.op = OP_UPD_SLOW;
                n_state  = ST_DIF;
            end
            ST_DIF: begin
                o_cmd.op = OP_DIF;
                n_state  = (r_pos == POS_ONE) ? ST_SEED : ST_SIGD;
            end
            ST_SEED: begin
                o_cmd.op = OP_SEED;
                n_pos    = POS_MANY;
                n_state  = ST_DONE;
            end
            ST_SIGD: begin
                o_cmd.op = OP_SIG_DIFF;
                n_state  = ST_MULG;
            end
            ST_MULG: begin
                o_cmd.op = OP_MUL_SIG;
                n_state  = ST_UPDG;
            end
            ST_UPDG: begin
                o_cmd.op = OP_UPD_SIG;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= POS_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* design/macd_indicator.sv */
// ----------------------------------------------------------------------------
// macd_indicator: fixed-point MACD indicator
// Keeps fast and slow exponential averages of the closing price and a signal
// average of their difference, answering DIF, DEA and histogram per bar.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  -------   ---------  ---------------------------------------------------
//  s         in         tdata = close_price, tuser = series_start
//  m         out        tdata = dif_value, dea_value, hist_value
//  cfg       in         index and 17-bit weight for one register
//
// A bar that starts a series loads the averages with its price; the second
// bar updates fast and slow and seeds DEA, every later bar updates all three
// averages. The single shared multiplier serves the fast, slow and signal
// updates in turn with a register after every product. Reset is
// synchronous and active low; it restores the default weights and clears
// the averages so that the next bar starts a series. A finished result waits
// in the output register while the following bar is accepted; a bar whose
// work is done waits only if that register is still occupied.
//
module macd_indicator import macd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Bar input
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [PRICE_W-1:0]   i_s_tdata,  // [31:0] close_price
    input  logic                 i_s_tuser,  // [0] series_start
    // Result output
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_W-1:0]     o_m_tdata,  // [48:0] dif_value, [97:49] dea_value,
                                             // [147:98] hist_value, rest zero
    // Configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd w_cmd;
    logic    w_cfg_we;

    // Weights are plain registers, so a write is always taken at once.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;

    // The controller decides restart versus update from the start flag and
    // its own record of how far into the series it is.
    macd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_tvalid),
        .i_series_start (i_s_tuser),
        .o_in_ready     (o_s_tready),
        .o_out_valid    (o_m_tvalid),
        .i_out_ready    (i_m_tready),
        .o_cmd          (w_cmd)
    );

    // The datapath holds the averages and the output register.
    macd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_price     (i_s_tdata),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_m_tdata)
    );

endmodule
